// ----- design/pwfd_pkg.sv -----
`default_nettype none
package pwfd_pkg;

    localparam int unsigned DUR_W   = 16;
    localparam int unsigned VALUE_W = 64;
    localparam int unsigned BITS_W  = 8;
    localparam int unsigned CFG_W   = 64;
    localparam int unsigned IDX_W   = 3;

    localparam logic [IDX_W-1:0] REG_SYNC_WINDOW = 3'd0;
    localparam logic [IDX_W-1:0] REG_ONE_WINDOW  = 3'd1;
    localparam logic [IDX_W-1:0] REG_ZERO_WINDOW = 3'd2;
    localparam logic [IDX_W-1:0] REG_LEAST_BITS  = 3'd3;

    typedef struct packed {
        logic [DUR_W-1:0] duration;
        logic             last;
    } t_in;

    typedef struct packed {
        logic               frame_valid;
        logic [VALUE_W-1:0] frame_value;
        logic [BITS_W-1:0]  bit_count;
        logic [DUR_W-1:0]   consumed;
    } t_out;

    typedef struct packed {
        logic [31:0]       sync_window;
        logic [63:0]       one_window;
        logic [63:0]       zero_window;
        logic [BITS_W-1:0] least_bits;
    } t_cfg;

    // A window whose minimum exceeds its maximum matches nothing.
    function automatic logic in_range(input logic [DUR_W-1:0] d,
                                      input logic [31:0] w);
        return (d >= w[15:0]) && (d <= w[31:16]);
    endfunction

    function automatic logic pair_match(input logic [DUR_W-1:0] h,
                                        input logic [DUR_W-1:0] l,
                                        input logic [63:0] w);
        return in_range(h, w[31:0]) && in_range(l, w[63:32]);
    endfunction

endpackage
`default_nettype wire

// ----- design/pwfd_cfg_regs.sv -----
`default_nettype none
module pwfd_cfg_regs (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire logic [pwfd_pkg::IDX_W-1:0]    i_cfg_index,
    input  wire logic [pwfd_pkg::CFG_W-1:0]    i_cfg_data,
    output pwfd_pkg::t_cfg                     o_cfg
);

    localparam logic [pwfd_pkg::BITS_W-1:0] LEAST_BITS_RESET = 8'd8;

    pwfd_pkg::t_cfg r_cfg;

    // Indexes past the last register are ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.sync_window <= '0;
            r_cfg.one_window  <= '0;
            r_cfg.zero_window <= '0;
            r_cfg.least_bits  <= LEAST_BITS_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                pwfd_pkg::REG_SYNC_WINDOW: r_cfg.sync_window <= i_cfg_data[31:0];
                pwfd_pkg::REG_ONE_WINDOW:  r_cfg.one_window  <= i_cfg_data;
                pwfd_pkg::REG_ZERO_WINDOW: r_cfg.zero_window <= i_cfg_data;
                pwfd_pkg::REG_LEAST_BITS:
                    r_cfg.least_bits <= i_cfg_data[pwfd_pkg::BITS_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule
`default_nettype wire

// ----- design/pulse_width_frame_decoder_unit.sv -----
`default_nettype none
// Pulse-width frame decoder.
// Input channel: one duration per beat (i_in_valid / o_in_stall / i_in_data),
// with the last flag on the final duration of a buffer. The first duration
// must fall in the sync window; later high/low pairs are decoded as one or
// zero bits, shifted in first bit most significant.
// Output channel: exactly one beat per buffer (o_out_valid / i_out_stall /
// o_out_data), carrying valid flag, value, bit count and consumed count.
// Configuration: a write on i_cfg_we stores i_cfg_data in the register named
// by i_cfg_index; it should happen only while no buffer is in flight.
// Result path: a buffer's last beat is accepted into the input register and
// decoded from there into the result register, which offers the result; a
// stalled waiting result can hold the last beat in the input register.
// Throughput: one duration per cycle while no last duration is held, set by
// the single decode step between the input register and the result register.
// Reset (synchronous, active low) clears the frame state, empties both
// registers and loads the register defaults.
// While the receiver stalls a waiting result, non-last durations keep
// flowing; a last duration is held, and the input stalls behind it.
module pulse_width_frame_decoder_unit (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    output      logic                          o_in_stall,
    input  wire pwfd_pkg::t_in                 i_in_data,
    output      logic                          o_out_valid,
    input  wire logic                          i_out_stall,
    output      pwfd_pkg::t_out                o_out_data,
    input  wire logic                          i_cfg_we,
    input  wire logic [pwfd_pkg::IDX_W-1:0]    i_cfg_index,
    input  wire logic [pwfd_pkg::CFG_W-1:0]    i_cfg_data
);

    localparam logic [1:0] PH_SYNC = 2'd0;
    localparam logic [1:0] PH_HIGH = 2'd1;
    localparam logic [1:0] PH_LOW  = 2'd2;
    localparam logic [1:0] PH_DONE = 2'd3;
    localparam logic [pwfd_pkg::DUR_W-1:0] IDX_MAX = '1;

    pwfd_pkg::t_cfg cfg;

    pwfd_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    logic                             r_in_valid;
    pwfd_pkg::t_in                    r_in;
    logic                             r_out_valid;
    pwfd_pkg::t_out                   r_out;

    logic [1:0]                       r_phase,  n_phase;
    logic [pwfd_pkg::DUR_W-1:0]       r_held,   n_held;
    logic [pwfd_pkg::VALUE_W-1:0]     r_shift,  n_shift;
    logic [pwfd_pkg::BITS_W-1:0]      r_bits,   n_bits;
    logic [pwfd_pkg::DUR_W-1:0]       r_index,  n_index;
    logic                             r_verdict, n_verdict;

    logic                             emit;
    pwfd_pkg::t_out                   result;
    logic                             advance;
    logic                             in_take;
    logic [pwfd_pkg::DUR_W-1:0]       idx_next;
    logic                             one_hit;
    logic                             zero_hit;
    logic [pwfd_pkg::VALUE_W-1:0]     shift_in;
    logic [pwfd_pkg::BITS_W-1:0]      bits_inc;

    function automatic logic frame_ok(input logic [pwfd_pkg::BITS_W-1:0] bits,
                                      input logic [pwfd_pkg::BITS_W-1:0] floor_bits);
        return (bits >= floor_bits) && !bits[0];
    endfunction

    // Only a last beat produces a result, so only it can be held up by a full
    // result register.
    assign advance    = !(r_in_valid && r_in.last && r_out_valid && i_out_stall);
    assign o_in_stall = r_in_valid && !advance;
    assign in_take    = i_in_valid && !o_in_stall;

    assign idx_next = (r_index != IDX_MAX) ? r_index + 1'b1 : r_index;
    assign one_hit  = pwfd_pkg::pair_match(r_held, r_in.duration, cfg.one_window);
    assign zero_hit = pwfd_pkg::pair_match(r_held, r_in.duration, cfg.zero_window);
    assign shift_in = {r_shift[pwfd_pkg::VALUE_W-2:0], one_hit};
    assign bits_inc = r_bits + 1'b1;

    always_comb begin
        n_phase   = r_phase;
        n_held    = r_held;
        n_shift   = r_shift;
        n_bits    = r_bits;
        n_index   = r_index;
        n_verdict = r_verdict;
        emit      = 1'b0;
        result    = '0;
        case (r_phase)
            PH_SYNC: begin
                if (r_in.last) begin
                    emit = 1'b1;
                end else begin
                    n_index = idx_next;
                    if (pwfd_pkg::in_range(r_in.duration, cfg.sync_window)) begin
                        n_phase = PH_HIGH;
                    end else begin
                        n_verdict = 1'b0;
                        n_phase   = PH_DONE;
                    end
                end
            end
            PH_HIGH: begin
                n_held  = r_in.duration;
                n_index = idx_next;
                n_phase = PH_LOW;
                if (r_in.last) begin
                    emit               = 1'b1;
                    result.frame_valid = frame_ok(r_bits, cfg.least_bits);
                    result.frame_value = r_shift;
                    result.bit_count   = r_bits;
                    result.consumed    = idx_next;
                end
            end
            PH_LOW: begin
                if (one_hit || zero_hit) begin
                    n_shift = shift_in;
                    n_bits  = bits_inc;
                    n_index = idx_next;
                    n_phase = PH_HIGH;
                    if (r_in.last) begin
                        emit               = 1'b1;
                        result.frame_valid = frame_ok(bits_inc, cfg.least_bits);
                        result.frame_value = shift_in;
                        result.bit_count   = bits_inc;
                        result.consumed    = idx_next;
                    end
                end else begin
                    // The frame ends before the unmatched pair.
                    n_verdict = frame_ok(r_bits, cfg.least_bits);
                    n_phase   = PH_DONE;
                    if (r_in.last) begin
                        emit               = 1'b1;
                        result.frame_valid = n_verdict;
                        result.frame_value = r_shift;
                        result.bit_count   = r_bits;
                        result.consumed    = r_index;
                    end
                end
            end
            default: begin
                if (r_in.last) begin
                    emit               = 1'b1;
                    result.frame_valid = r_verdict;
                    result.frame_value = r_shift;
                    result.bit_count   = r_bits;
                    result.consumed    = r_index;
                end
            end
        endcase
        // An invalid frame reports all zeros, and every result starts a new
        // buffer.
        if (emit) begin
            if (!result.frame_valid) begin
                result = '0;
            end
            n_phase   = PH_SYNC;
            n_held    = '0;
            n_shift   = '0;
            n_bits    = '0;
            n_index   = '0;
            n_verdict = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_phase     <= PH_SYNC;
            r_held      <= '0;
            r_shift     <= '0;
            r_bits      <= '0;
            r_index     <= '0;
            r_verdict   <= 1'b0;
        end else begin
            if (in_take) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (r_in_valid && advance) begin
                r_phase   <= n_phase;
                r_held    <= n_held;
                r_shift   <= n_shift;
                r_bits    <= n_bits;
                r_index   <= n_index;
                r_verdict <= n_verdict;
            end
            if (r_in_valid && advance && emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in <= i_in_data;
        end
        if (r_in_valid && advance && emit) begin
            r_out <= result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    a_invalid_is_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_data.frame_valid) |->
            (o_out_data.frame_value == '0 && o_out_data.bit_count == '0 &&
             o_out_data.consumed == '0))
        else $error("invalid frame carries nonzero fields");

    a_valid_even: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.frame_valid) |-> !o_out_data.bit_count[0])
        else $error("valid frame with odd bit count");

    a_sync_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_SYNC) |-> (r_bits == '0 && r_index == '0 && r_shift == '0))
        else $error("frame state not cleared while waiting for sync");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_out_stall) |=> (r_out_valid && $stable(r_out)))
        else $error("waiting result overwritten or dropped");

    a_stall_on_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && r_in.last && r_out_valid && i_out_stall) |-> o_in_stall)
        else $error("last beat not held while result is stalled");

endmodule
`default_nettype wire

// ----- sim/tb_top.sv -----
module tb_top;

    typedef enum logic [1:0] {SEEK_SYNC, SEEK_HIGH, SEEK_LOW, DISCARD} t_seek;

    localparam logic [pwfd_pkg::IDX_W-1:0] REG_SPARE = 3'd7;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES  = 4;
    localparam int MAX_REPORTS    = 10;

    logic                            clk       = 1'b0;
    logic                            rst_n     = 1'b0;
    logic                            in_valid  = 1'b0;
    logic                            in_stall;
    pwfd_pkg::t_in                   in_beat   = '0;
    logic                            out_valid;
    logic                            out_stall = 1'b0;
    pwfd_pkg::t_out                  out_beat;
    logic                            cfg_we    = 1'b0;
    logic [pwfd_pkg::IDX_W-1:0]      cfg_index = '0;
    logic [pwfd_pkg::CFG_W-1:0]      cfg_data  = '0;

    // Register copy and frame state of the decoder as the testbench sees it.
    pwfd_pkg::t_cfg regs = '{sync_window: '0, one_window: '0, zero_window: '0,
                             least_bits: 8'd8};
    t_seek       seek        = SEEK_SYNC;
    logic [15:0] held_high   = '0;
    logic [63:0] shift_reg   = '0;
    logic [7:0]  bit_total   = '0;
    logic [15:0] beat_index  = '0;
    logic        verdict     = 1'b0;

    pwfd_pkg::t_in  pending_durations[$];
    pwfd_pkg::t_out expected_frames[$];
    pwfd_pkg::t_out want_frame;

    int idle_pct     = 0;
    int gap_left     = 0;
    int stall_left   = 0;
    int mismatches   = 0;
    int quiet_cycles = 0;

    pulse_width_frame_decoder_unit DUT (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_beat),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_beat),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    function automatic logic fits(input logic [15:0] d, input logic [31:0] win);
        return (d >= win[15:0]) && (d <= win[31:16]);
    endfunction

    function automatic logic pair_fits(input logic [15:0] h, input logic [15:0] l,
                                       input logic [63:0] win);
        return fits(h, win[31:0]) && fits(l, win[63:32]);
    endfunction

    function automatic logic frame_good();
        return (bit_total >= regs.least_bits) && !bit_total[0];
    endfunction

    task automatic close_frame(input logic ok, input logic [15:0] used);
        pwfd_pkg::t_out f;
        f.frame_valid = ok;
        f.frame_value = ok ? shift_reg : '0;
        f.bit_count   = ok ? bit_total : '0;
        f.consumed    = ok ? used : '0;
        expected_frames.push_back(f);
        seek       = SEEK_SYNC;
        held_high  = '0;
        shift_reg  = '0;
        bit_total  = '0;
        beat_index = '0;
        verdict    = 1'b0;
    endtask

    task automatic decode_duration(input pwfd_pkg::t_in beat);
        logic [15:0] pos;
        logic [15:0] nxt;
        logic        as_one;
        logic        as_zero;
        pos     = beat_index;
        nxt     = (pos != 16'hFFFF) ? pos + 16'd1 : pos;
        as_one  = pair_fits(held_high, beat.duration, regs.one_window);
        as_zero = pair_fits(held_high, beat.duration, regs.zero_window);
        case (seek)
            SEEK_SYNC: begin
                if (beat.last) begin
                    close_frame(1'b0, '0);
                end else begin
                    beat_index = nxt;
                    if (fits(beat.duration, regs.sync_window)) begin
                        seek = SEEK_HIGH;
                    end else begin
                        verdict = 1'b0;
                        seek    = DISCARD;
                    end
                end
            end
            SEEK_HIGH: begin
                held_high  = beat.duration;
                beat_index = nxt;
                if (beat.last) begin
                    close_frame(frame_good(), beat_index);
                end else begin
                    seek = SEEK_LOW;
                end
            end
            SEEK_LOW: begin
                if (as_one || as_zero) begin
                    // A pair inside both windows decodes as a one.
                    shift_reg  = {shift_reg[62:0], as_one};
                    bit_total  = bit_total + 8'd1;
                    beat_index = nxt;
                    if (beat.last) begin
                        close_frame(frame_good(), beat_index);
                    end else begin
                        seek = SEEK_HIGH;
                    end
                end else begin
                    // The decision is taken here and held until the buffer ends.
                    verdict = frame_good();
                    if (beat.last) begin
                        close_frame(verdict, pos);
                    end else begin
                        seek = DISCARD;
                    end
                end
            end
            default: begin
                if (beat.last) begin
                    close_frame(verdict, beat_index);
                end
            end
        endcase
    endtask

    // Sender: holds a stalled beat, otherwise presents the next pending one or idles.
    always @(posedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && !in_stall) begin
                decode_duration(in_beat);
            end
            if (!(in_valid && in_stall)) begin
                if (gap_left > 0) begin
                    gap_left = gap_left - 1;
                    in_valid <= 1'b0;
                end else if (pending_durations.size() > 0) begin
                    in_valid <= 1'b1;
                    in_beat  <= pending_durations.pop_front();
                    if ($urandom_range(99, 0) < idle_pct) begin
                        gap_left = $urandom_range(15, 1);
                    end
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: checks each accepted result beat and stalls in bursts.
    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall) begin
            if (expected_frames.size() == 0) begin
                mismatches = mismatches + 1;
                if (mismatches <= MAX_REPORTS) begin
                    $display("unexpected result: valid %0b value %h bits %0d consumed %0d",
                             out_beat.frame_valid, out_beat.frame_value,
                             out_beat.bit_count, out_beat.consumed);
                end
            end else begin
                want_frame = expected_frames.pop_front();
                if (out_beat.frame_valid !== want_frame.frame_valid ||
                    out_beat.frame_value !== want_frame.frame_value ||
                    out_beat.bit_count !== want_frame.bit_count ||
                    out_beat.consumed !== want_frame.consumed) begin
                    mismatches = mismatches + 1;
                    if (mismatches <= MAX_REPORTS) begin
                        $display("result mismatch: exp valid %0b value %h bits %0d consumed %0d",
                                 want_frame.frame_valid, want_frame.frame_value,
                                 want_frame.bit_count, want_frame.consumed);
                        $display("                 got valid %0b value %h bits %0d consumed %0d",
                                 out_beat.frame_valid, out_beat.frame_value,
                                 out_beat.bit_count, out_beat.consumed);
                    end
                end
            end
        end
        if (stall_left > 0) begin
            stall_left = stall_left - 1;
            out_stall <= 1'b1;
        end else if (rst_n && $urandom_range(99, 0) < idle_pct) begin
            stall_left = $urandom_range(14, 0);
            out_stall <= 1'b1;
        end else begin
            out_stall <= 1'b0;
        end
    end

    always @(posedge clk) begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    function automatic pwfd_pkg::t_in beat_of(input logic [15:0] d, input logic l);
        pwfd_pkg::t_in b;
        b.duration = d;
        b.last     = l;
        return b;
    endfunction

    function automatic logic [15:0] pick_in(input logic [31:0] win);
        if (win[15:0] <= win[31:16]) begin
            return 16'($urandom_range(win[31:16], win[15:0]));
        end
        return 16'($urandom);
    endfunction

    task automatic queue_beat(input logic [15:0] d, input logic l);
        pending_durations.push_back(beat_of(d, l));
    endtask

    // A sync, then pairs drawn from the current windows, optionally a lone
    // trailing high and one duration overwritten with noise.
    task automatic queue_frame(input int pairs, input logic trailing, input logic corrupt);
        pwfd_pkg::t_in beats[$];
        logic [63:0]   win;
        beats.push_back(beat_of(pick_in(regs.sync_window), 1'b0));
        for (int k = 0; k < pairs; k++) begin
            win = $urandom_range(1, 0) ? regs.one_window : regs.zero_window;
            beats.push_back(beat_of(pick_in(win[31:0]), 1'b0));
            beats.push_back(beat_of(pick_in(win[63:32]), 1'b0));
        end
        if (trailing) begin
            beats.push_back(beat_of(pick_in(regs.one_window[31:0]), 1'b0));
        end
        if (corrupt) begin
            beats[$urandom_range(beats.size() - 1, 0)].duration = 16'($urandom);
        end
        beats[beats.size() - 1].last = 1'b1;
        pending_durations = {pending_durations, beats};
    endtask

    task automatic queue_noise(input int len);
        logic [15:0] d;
        for (int k = 0; k < len; k++) begin
            case ($urandom_range(3, 0))
                0: d = 16'h0000;
                1: d = 16'hFFFF;
                default: d = 16'($urandom);
            endcase
            queue_beat(d, k == len - 1);
        end
    endtask

    task automatic fill_random(input int target);
        int roll;
        while (pending_durations.size() < target) begin
            roll = $urandom_range(99, 0);
            if (roll < 70) begin
                queue_frame($urandom_range(24, 0), 1'($urandom_range(1, 0)), 1'b0);
            end else if (roll < 78) begin
                queue_frame($urandom_range(90, 25), 1'($urandom_range(1, 0)), 1'b0);
            end else if (roll < 88) begin
                queue_frame($urandom_range(24, 0), 1'($urandom_range(1, 0)), 1'b1);
            end else begin
                queue_noise($urandom_range(12, 1));
            end
        end
    endtask

    task automatic put_reg(input logic [pwfd_pkg::IDX_W-1:0] idx,
                           input logic [pwfd_pkg::CFG_W-1:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        case (idx)
            pwfd_pkg::REG_SYNC_WINDOW: regs.sync_window = val[31:0];
            pwfd_pkg::REG_ONE_WINDOW:  regs.one_window  = val;
            pwfd_pkg::REG_ZERO_WINDOW: regs.zero_window = val;
            pwfd_pkg::REG_LEAST_BITS:  regs.least_bits  = val[7:0];
            default: ;
        endcase
    endtask

    // Unused upper data bits and an unmapped index carry random values;
    // the block must ignore both.
    task automatic write_regs(input logic [31:0] sync, input logic [63:0] one,
                              input logic [63:0] zero, input logic [7:0] minb);
        put_reg(pwfd_pkg::REG_SYNC_WINDOW, {32'($urandom), sync});
        put_reg(pwfd_pkg::REG_ONE_WINDOW, one);
        put_reg(pwfd_pkg::REG_ZERO_WINDOW, zero);
        put_reg(pwfd_pkg::REG_LEAST_BITS, {32'($urandom), 24'($urandom), minb});
        put_reg(REG_SPARE, {32'($urandom), 32'($urandom)});
        @(posedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    task automatic write_typical(input logic [7:0] minb);
        logic [15:0] s_lo;
        logic [15:0] h_lo;
        logic [15:0] o_lo;
        logic [15:0] z_lo;
        logic [15:0] zh_lo;
        s_lo  = 16'($urandom_range(20000, 2000));
        h_lo  = 16'($urandom_range(1000, 100));
        zh_lo = 16'($urandom_range(1000, 100));
        o_lo  = 16'($urandom_range(3000, 1200));
        z_lo  = 16'($urandom_range(1100, 100));
        write_regs({s_lo + 16'($urandom_range(4000, 0)), s_lo},
                   {o_lo + 16'($urandom_range(600, 0)), o_lo,
                    h_lo + 16'($urandom_range(400, 0)), h_lo},
                   {z_lo + 16'($urandom_range(600, 0)), z_lo,
                    zh_lo + 16'($urandom_range(400, 0)), zh_lo},
                   minb);
    endtask

    // Returns once everything sent is decoded and the pipeline has drained.
    task automatic wait_idle();
        do begin
            @(negedge clk);
        end while (pending_durations.size() > 0 || in_valid || expected_frames.size() > 0);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    initial begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Register defaults: only zero durations fit the windows.
        idle_pct = 20;
        queue_beat(16'h0000, 1'b1);
        queue_beat(16'hFFFF, 1'b0);
        queue_beat(16'h0001, 1'b0);
        queue_beat(16'h0000, 1'b1);
        for (int k = 0; k < 5; k++) begin
            queue_beat(16'h0000, k == 4);
        end
        wait_idle();

        write_regs({16'd10000, 16'd8000}, {16'd1800, 16'd1500, 16'd700, 16'd500},
                   {16'd700, 16'd500, 16'd700, 16'd500}, 8'd2);
        // Clean two-bit frame, a frame cut by an unmatched low on the last
        // beat, and a frame ending in a lone high.
        queue_beat(16'd9000, 1'b0);
        queue_beat(16'd600, 1'b0);
        queue_beat(16'd1600, 1'b0);
        queue_beat(16'd600, 1'b0);
        queue_beat(16'd600, 1'b1);
        queue_beat(16'd9000, 1'b0);
        queue_beat(16'd600, 1'b0);
        queue_beat(16'd600, 1'b0);
        queue_beat(16'd600, 1'b0);
        queue_beat(16'd1600, 1'b0);
        queue_beat(16'd600, 1'b0);
        queue_beat(16'd9999, 1'b1);
        queue_beat(16'd9000, 1'b0);
        queue_beat(16'd600, 1'b0);
        queue_beat(16'd1600, 1'b0);
        queue_beat(16'd600, 1'b0);
        queue_beat(16'd600, 1'b0);
        queue_beat(16'd600, 1'b1);
        wait_idle();

        // One long buffer: the bit count wraps past 255 and only the latest
        // 64 bits are kept.
        idle_pct = 0;
        write_regs({16'hFFFF, 16'h0000}, {16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000},
                   {16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000}, 8'd8);
        queue_frame(264, 1'b0, 1'b0);
        wait_idle();

        for (int p = 0; p < 8; p++) begin
            case (p)
                0: begin
                    write_typical(8'($urandom_range(16, 0)));
                    idle_pct = 25;
                end
                1: begin
                    write_regs({16'hFFFF, 16'h0000},
                               {16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000},
                               {16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000}, 8'd0);
                    idle_pct = 0;
                end
                2: begin
                    write_typical(8'd8);
                    idle_pct = 30;
                end
                3: begin
                    // The one window is inverted and can never match.
                    write_regs({16'd10000, 16'd8000},
                               {16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF},
                               {16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000}, 8'd255);
                    idle_pct = 10;
                end
                4: begin
                    write_regs('0, '0, '0, 8'd0);
                    idle_pct = 20;
                end
                5: begin
                    write_regs(32'($urandom), {32'($urandom), 32'($urandom)},
                               {32'($urandom), 32'($urandom)}, 8'($urandom));
                    idle_pct = 15;
                end
                6: begin
                    write_typical(8'd2);
                    idle_pct = 20;
                end
                default: begin
                    write_typical(8'd8);
                    idle_pct = 0;
                end
            endcase
            fill_random(50);
            wait_idle();
        end

        if (mismatches == 0 && expected_frames.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
